// File: rtl/cefm_pkg.sv
// Shared types, constants and field helpers for the cubic extension multiplier.
// Base field is the 64-bit prime p = 2^64 - 2^32 + 1. No dependencies.
`default_nettype none

package cefm_pkg;

   localparam int unsigned COEF_W = 64;
   localparam int unsigned HALF_W = 32;
   localparam int unsigned NUM_PRODUCTS = 6;

   localparam logic [COEF_W-1:0] FIELD_P   = 64'hFFFF_FFFF_0000_0001;
   localparam logic [COEF_W-1:0] FIELD_EPS = 64'h0000_0000_FFFF_FFFF;

   // Karatsuba product slots
   localparam int unsigned PROD_A = 0;  // (a0+a1)(b0+b1)
   localparam int unsigned PROD_B = 1;  // (a0+a2)(b0+b2)
   localparam int unsigned PROD_C = 2;  // (a1+a2)(b1+b2)
   localparam int unsigned PROD_D = 3;  // a0*b0
   localparam int unsigned PROD_E = 4;  // a1*b1
   localparam int unsigned PROD_F = 5;  // a2*b2

   typedef logic [COEF_W-1:0] coef_type;

   typedef struct packed {
      coef_type a_coef0;
      coef_type a_coef1;
      coef_type a_coef2;
      coef_type b_coef0;
      coef_type b_coef1;
      coef_type b_coef2;
   } cefm_req_type;

   typedef struct packed {
      coef_type prod_coef0;
      coef_type prod_coef1;
      coef_type prod_coef2;
   } cefm_rsp_type;

   // Bring any 64-bit value into 0..p-1.
   function automatic coef_type fcanon(input coef_type v);
      coef_type r;
      r = (v >= FIELD_P) ? v - FIELD_P : v;
      return r;
   endfunction

   // Modular add of two canonical values.
   function automatic coef_type fadd(input coef_type a, input coef_type b);
      logic [COEF_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, FIELD_P}) begin
         s = s - {1'b0, FIELD_P};
      end
      return s[COEF_W-1:0];
   endfunction

   // Modular subtract of two canonical values.
   function automatic coef_type fsub(input coef_type a, input coef_type b);
      coef_type d;
      d = a - b;
      if (a < b) begin
         d = d + FIELD_P;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cefm_mul.sv
// Five-stage pipelined base-field multiplier: a * b mod p, canonical result.
// Uses cefm_pkg for the field constants and canonicalization.
`default_nettype none

module cefm_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire cefm_pkg::coef_type    in_a,
   input  wire cefm_pkg::coef_type    in_b,
   output logic                       out_valid,
   output cefm_pkg::coef_type         out_prod
);
   import cefm_pkg::*;

   // stage 1: four 32x32 partial products
   logic [COEF_W-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [COEF_W-1:0] ll_in, lh_in, hl_in, hh_in;
   // stage 2: full 128-bit product
   logic [2*COEF_W-1:0] full_ff, full_in;
   logic [COEF_W:0]     mid_sum;
   // stage 3: folded terms
   coef_type t_ff, t_in, u_ff, u_in;
   logic [HALF_W-1:0] top_w, upper_w;
   coef_type lo_w;
   // stage 4: raw reduced value, below 2^64
   coef_type r_ff, r_in;
   logic [COEF_W:0] tu_sum;
   // stage 5: canonical result
   coef_type prod_ff, prod_in;
   logic [4:0] valid_ff;

   always_comb begin
      ll_in = {{HALF_W{1'b0}}, in_a[HALF_W-1:0]} * {{HALF_W{1'b0}}, in_b[HALF_W-1:0]};
      lh_in = {{HALF_W{1'b0}}, in_a[HALF_W-1:0]} * {{HALF_W{1'b0}}, in_b[COEF_W-1:HALF_W]};
      hl_in = {{HALF_W{1'b0}}, in_a[COEF_W-1:HALF_W]} * {{HALF_W{1'b0}}, in_b[HALF_W-1:0]};
      hh_in = {{HALF_W{1'b0}}, in_a[COEF_W-1:HALF_W]} * {{HALF_W{1'b0}}, in_b[COEF_W-1:HALF_W]};
   end

   always_comb begin
      mid_sum = {1'b0, lh_ff} + {1'b0, hl_ff};
      full_in = {hh_ff, ll_ff} + {{(HALF_W-1){1'b0}}, mid_sum, {HALF_W{1'b0}}};
   end

   // 2^64 = 2^32 - 1 and 2^96 = -1 mod p
   always_comb begin
      lo_w    = full_ff[COEF_W-1:0];
      upper_w = full_ff[COEF_W+HALF_W-1:COEF_W];
      top_w   = full_ff[2*COEF_W-1:COEF_W+HALF_W];
      t_in    = lo_w - {{HALF_W{1'b0}}, top_w};
      if (lo_w < {{HALF_W{1'b0}}, top_w}) begin
         t_in = t_in + FIELD_P;
      end
      u_in = {upper_w, {HALF_W{1'b0}}} - {{HALF_W{1'b0}}, upper_w};
   end

   always_comb begin
      tu_sum = {1'b0, t_ff} + {1'b0, u_ff};
      // wrap past 2^64: add back 2^64 mod p
      r_in = tu_sum[COEF_W] ? tu_sum[COEF_W-1:0] + FIELD_EPS : tu_sum[COEF_W-1:0];
   end

   always_comb begin
      prod_in = fcanon(r_ff);
   end

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      lh_ff   <= lh_in;
      hl_ff   <= hl_in;
      hh_ff   <= hh_in;
      full_ff <= full_in;
      t_ff    <= t_in;
      u_ff    <= u_in;
      r_ff    <= r_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   assign out_valid = valid_ff[4];
   assign out_prod  = prod_ff;

endmodule

`default_nettype wire

// File: rtl/cubic_ext_field_multiply.sv
// Top level of the cubic extension field multiplier over p = 2^64 - 2^32 + 1.
// Depends on cefm_pkg and instantiates six cefm_mul units.
//
// Usage: drive req_data with operands a and b (three coefficients each, any
// 64-bit value, taken mod p) and raise start for one cycle per request. busy
// is always low, so a request is taken at every edge where start is high;
// a new request may follow in every cycle.
// The product (reduced by x^3 = x + 1, canonical coefficients) appears on
// rsp_data for exactly one cycle with rsp_strobe high. Throughput is one
// request per cycle. The pipeline is: input register, canonicalize, operand
// sums, five multiplier stages (32x32 partial products, 128-bit sum, two
// fold steps, final canonicalize), then four stages of modular add/subtract.
// The receiver cannot stall; results are presented once and never held.
// Synchronous reset clears all valid bits; requests in flight are dropped.
`default_nettype none

module cubic_ext_field_multiply (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire cefm_pkg::cefm_req_type req_data,
   output logic                        busy,
   output logic                        rsp_strobe,
   output cefm_pkg::cefm_rsp_type      rsp_data
);
   import cefm_pkg::*;

   cefm_req_type req_ff;
   logic         v_req_ff;
   coef_type     ca_ff [3];
   coef_type     cb_ff [3];
   logic         v_canon_ff;
   coef_type     opa_ff [NUM_PRODUCTS];
   coef_type     opb_ff [NUM_PRODUCTS];
   logic         v_sum_ff;
   coef_type     prod_w [NUM_PRODUCTS];
   logic [NUM_PRODUCTS-1:0] mul_valid;

   // combine stages
   coef_type g_ff, h_ff, b8_ff, c8_ff, d8_ff, e8_ff, f8_ff;
   logic     v8_ff;
   coef_type y0_ff, y1_ff, c2_9_ff, d9_ff, e9_ff, f9_ff;
   logic     v9_ff;
   coef_type c0_10_ff, z1_ff, c2_10_ff, d10_ff;
   logic     v10_ff;
   cefm_rsp_type rsp_ff, rsp_in;
   logic         strobe_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      req_ff <= req_data;
      ca_ff[0] <= fcanon(req_ff.a_coef0);
      ca_ff[1] <= fcanon(req_ff.a_coef1);
      ca_ff[2] <= fcanon(req_ff.a_coef2);
      cb_ff[0] <= fcanon(req_ff.b_coef0);
      cb_ff[1] <= fcanon(req_ff.b_coef1);
      cb_ff[2] <= fcanon(req_ff.b_coef2);
      opa_ff[PROD_A] <= fadd(ca_ff[0], ca_ff[1]);
      opb_ff[PROD_A] <= fadd(cb_ff[0], cb_ff[1]);
      opa_ff[PROD_B] <= fadd(ca_ff[0], ca_ff[2]);
      opb_ff[PROD_B] <= fadd(cb_ff[0], cb_ff[2]);
      opa_ff[PROD_C] <= fadd(ca_ff[1], ca_ff[2]);
      opb_ff[PROD_C] <= fadd(cb_ff[1], cb_ff[2]);
      opa_ff[PROD_D] <= ca_ff[0];
      opb_ff[PROD_D] <= cb_ff[0];
      opa_ff[PROD_E] <= ca_ff[1];
      opb_ff[PROD_E] <= cb_ff[1];
      opa_ff[PROD_F] <= ca_ff[2];
      opb_ff[PROD_F] <= cb_ff[2];
   end

   for (genvar k = 0; k < NUM_PRODUCTS; k++) begin : g_mul
      cefm_mul u_mul (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_sum_ff),
         .in_a      (opa_ff[k]),
         .in_b      (opb_ff[k]),
         .out_valid (mul_valid[k]),
         .out_prod  (prod_w[k])
      );
   end

   // c0 = C + (D-E) - F, c1 = A + C - 2E - D, c2 = B - (D-E)
   always_ff @(posedge clock) begin
      g_ff  <= fsub(prod_w[PROD_D], prod_w[PROD_E]);
      h_ff  <= fadd(prod_w[PROD_A], prod_w[PROD_C]);
      b8_ff <= prod_w[PROD_B];
      c8_ff <= prod_w[PROD_C];
      d8_ff <= prod_w[PROD_D];
      e8_ff <= prod_w[PROD_E];
      f8_ff <= prod_w[PROD_F];

      y0_ff   <= fadd(c8_ff, g_ff);
      y1_ff   <= fsub(h_ff, e8_ff);
      c2_9_ff <= fsub(b8_ff, g_ff);
      d9_ff   <= d8_ff;
      e9_ff   <= e8_ff;
      f9_ff   <= f8_ff;

      c0_10_ff <= fsub(y0_ff, f9_ff);
      z1_ff    <= fsub(y1_ff, e9_ff);
      c2_10_ff <= c2_9_ff;
      d10_ff   <= d9_ff;

      rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_in.prod_coef0 = c0_10_ff;
      rsp_in.prod_coef1 = fsub(z1_ff, d10_ff);
      rsp_in.prod_coef2 = c2_10_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_req_ff   <= 1'b0;
         v_canon_ff <= 1'b0;
         v_sum_ff   <= 1'b0;
         v8_ff      <= 1'b0;
         v9_ff      <= 1'b0;
         v10_ff     <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         v_req_ff   <= start & ~busy;
         v_canon_ff <= v_req_ff;
         v_sum_ff   <= v_canon_ff;
         v8_ff      <= mul_valid[PROD_A];
         v9_ff      <= v8_ff;
         v10_ff     <= v9_ff;
         strobe_ff  <= v10_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   // all six multipliers advance in lockstep
   a_mul_lockstep: assert property (@(posedge clock) disable iff (reset)
      mul_valid == '0 || mul_valid == '1)
      else $error("multiplier valid bits disagree");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      start |-> ##12 rsp_strobe)
      else $error("request produced no result after 12 cycles");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 12))
      else $error("result without a matching request");

   a_rsp_canonical: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.prod_coef0 < FIELD_P) && (rsp_data.prod_coef1 < FIELD_P)
                     && (rsp_data.prod_coef2 < FIELD_P))
      else $error("result coefficient not canonical");
`endif

endmodule

`default_nettype wire
